>>> sv/vas_pkg.sv
package vas_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned PhaseW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHIRP_LED  = 3'd0,
    REG_ALERT_HALF = 3'd1,
    REG_PATROL_ON  = 3'd2,
    REG_PULSE      = 3'd3,
    REG_PATROL_OFF = 3'd4,
    REG_ARM_HOLD   = 3'd5,
    REG_BURST_CNT  = 3'd6,
    REG_PATROL_RND = 3'd7
  } reg_idx_t;

  typedef enum logic [PhaseW-1:0] {
    PH_ARM_WAIT     = 4'd0,
    PH_ARM_HOLD     = 4'd1,
    PH_BURST_IND    = 4'd2,
    PH_BURST_PWM    = 4'd3,
    PH_SPRING_SLEEP = 4'd4,
    PH_SPRING_CONF  = 4'd5,
    PH_CHIRP_IND    = 4'd6,
    PH_CHIRP_PWM    = 4'd7,
    PH_ALERT_IND    = 4'd8,
    PH_ALERT_PWM    = 4'd9,
    PH_PATROL_ON    = 4'd10,
    PH_PATROL_OFF   = 4'd11,
    PH_BALL_SLEEP   = 4'd12
  } phase_t;

  typedef struct packed {
    logic [TimerW-1:0] chirp_led_ms;
    logic [TimerW-1:0] alert_half_ms;
    logic [TimerW-1:0] patrol_on_ms;
    logic [TimerW-1:0] pulse_ms;
    logic [TimerW-1:0] patrol_off_ms;
    logic [TimerW-1:0] arm_hold_ms;
    logic [CountW-1:0] burst_count;
    logic [CountW-1:0] patrol_rounds;
  } cfg_t;

  typedef struct packed {
    logic              indicator_on;
    logic              pwm_on;
    logic              asleep;
    logic [PhaseW-1:0] phase_code;
  } result_t;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

endpackage

>>> sv/vas_if.sv
interface vas_in_if;
  logic valid;
  logic ready;
  logic ball_level;
  logic spring_level;

  modport source (output valid, ball_level, spring_level, input ready);
  modport sink (input valid, ball_level, spring_level, output ready);
endinterface

interface vas_out_if;
  logic                      valid;
  logic                      ready;
  logic                      indicator_on;
  logic                      pwm_on;
  logic                      asleep;
  logic [vas_pkg::PhaseW-1:0] phase_code;

  modport source (output valid, indicator_on, pwm_on, asleep, phase_code, input ready);
  modport sink (input valid, indicator_on, pwm_on, asleep, phase_code, output ready);
endinterface

>>> sv/vas_cfg_regs.sv
module vas_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [vas_pkg::CfgIdxW-1:0]   wr_idx,
  input  logic [vas_pkg::CfgDataW-1:0]  wr_data,
  output vas_pkg::cfg_t                 cfg
);

  vas_pkg::cfg_t cfg_r;
  vas_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (vas_pkg::reg_idx_t'(wr_idx))
        vas_pkg::REG_CHIRP_LED:  cfg_nxt.chirp_led_ms  = wr_data;
        vas_pkg::REG_ALERT_HALF: cfg_nxt.alert_half_ms = wr_data;
        vas_pkg::REG_PATROL_ON:  cfg_nxt.patrol_on_ms  = wr_data;
        vas_pkg::REG_PULSE:      cfg_nxt.pulse_ms      = wr_data;
        vas_pkg::REG_PATROL_OFF: cfg_nxt.patrol_off_ms = wr_data;
        vas_pkg::REG_ARM_HOLD:   cfg_nxt.arm_hold_ms   = wr_data;
        vas_pkg::REG_BURST_CNT:  cfg_nxt.burst_count   = wr_data[vas_pkg::CountW-1:0];
        vas_pkg::REG_PATROL_RND: cfg_nxt.patrol_rounds = wr_data[vas_pkg::CountW-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chirp_led_ms  <= 16'd50;
      cfg_r.alert_half_ms <= 16'd150;
      cfg_r.patrol_on_ms  <= 16'd300;
      cfg_r.pulse_ms      <= 16'd1000;
      cfg_r.patrol_off_ms <= 16'd2000;
      cfg_r.arm_hold_ms   <= 16'd2000;
      cfg_r.burst_count   <= 4'd3;
      cfg_r.patrol_rounds <= 4'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/vas_phase_fsm.sv
module vas_phase_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              ball,
  input  logic              spring,
  input  vas_pkg::cfg_t     cfg,
  output vas_pkg::result_t  res_nxt
);

  vas_pkg::phase_t                  phase_r, phase_nxt;
  logic [vas_pkg::TimerW-1:0]       timer_r, timer_nxt;
  logic [vas_pkg::CountW-1:0]       round_r, round_nxt;
  logic                             ball_seen_r, ball_seen_nxt;
  logic                             spring_seen_r, spring_seen_nxt;
  logic                             watch_ball_r, watch_ball_nxt;

  logic [vas_pkg::TimerW-1:0]       timer_inc;
  logic [vas_pkg::TimerW-1:0]       limit;
  logic                             done;
  logic [vas_pkg::CountW-1:0]       round_inc;
  logic                             ball_or;
  logic                             spring_or;

  assign timer_inc = (timer_r != vas_pkg::TimerMax) ? timer_r + 1'b1 : timer_r;
  assign round_inc = round_r + 1'b1;
  assign ball_or   = ball_seen_r | ball;
  assign spring_or = spring_seen_r | spring;

  // Every timed phase shares one saturating timer and one compare.
  always_comb begin
    case (phase_r)
      vas_pkg::PH_ARM_HOLD:    limit = cfg.arm_hold_ms;
      vas_pkg::PH_CHIRP_IND:   limit = cfg.chirp_led_ms;
      vas_pkg::PH_ALERT_IND,
      vas_pkg::PH_ALERT_PWM:   limit = cfg.alert_half_ms;
      vas_pkg::PH_PATROL_ON:   limit = cfg.patrol_on_ms;
      vas_pkg::PH_PATROL_OFF:  limit = cfg.patrol_off_ms;
      default:                 limit = cfg.pulse_ms;
    endcase
  end

  assign done = (timer_inc >= limit);

  // Next state.
  always_comb begin
    phase_nxt       = phase_r;
    timer_nxt       = timer_r;
    round_nxt       = round_r;
    ball_seen_nxt   = ball_seen_r;
    spring_seen_nxt = spring_seen_r;
    watch_ball_nxt  = watch_ball_r;
    case (phase_r)
      vas_pkg::PH_ARM_WAIT: begin
        if (ball) begin
          watch_ball_nxt = 1'b0;
          phase_nxt      = vas_pkg::PH_ARM_HOLD;
          timer_nxt      = '0;
        end
      end
      vas_pkg::PH_ARM_HOLD: begin
        timer_nxt = timer_inc;
        if (done) begin
          timer_nxt = '0;
          if (ball) begin
            round_nxt = '0;
            phase_nxt = vas_pkg::PH_BURST_IND;
          end else begin
            phase_nxt = watch_ball_r ? vas_pkg::PH_BALL_SLEEP : vas_pkg::PH_ARM_WAIT;
          end
        end
      end
      vas_pkg::PH_BURST_IND: begin
        timer_nxt = timer_inc;
        if (done) begin
          timer_nxt = '0;
          phase_nxt = vas_pkg::PH_BURST_PWM;
        end
      end
      vas_pkg::PH_BURST_PWM: begin
        timer_nxt = timer_inc;
        if (done) begin
          timer_nxt = '0;
          round_nxt = round_inc;
          if (round_inc >= cfg.burst_count) begin
            watch_ball_nxt = 1'b0;
            phase_nxt      = vas_pkg::PH_SPRING_SLEEP;
          end else begin
            phase_nxt = vas_pkg::PH_BURST_IND;
          end
        end
      end
      vas_pkg::PH_SPRING_SLEEP: begin
        if (spring) begin
          phase_nxt = vas_pkg::PH_SPRING_CONF;
          timer_nxt = '0;
        end
      end
      vas_pkg::PH_SPRING_CONF: begin
        timer_nxt = timer_inc;
        if (done) begin
          timer_nxt = '0;
          if (spring) begin
            ball_seen_nxt   = ball;
            spring_seen_nxt = spring;
            phase_nxt       = vas_pkg::PH_ALERT_IND;
          end else begin
            phase_nxt = vas_pkg::PH_CHIRP_IND;
          end
        end
      end
      vas_pkg::PH_CHIRP_IND: begin
        timer_nxt = timer_inc;
        if (done) begin
          timer_nxt = '0;
          phase_nxt = vas_pkg::PH_CHIRP_PWM;
        end
      end
      vas_pkg::PH_CHIRP_PWM: begin
        timer_nxt = timer_inc;
        if (done) begin
          timer_nxt = '0;
          phase_nxt = vas_pkg::PH_SPRING_SLEEP;
        end
      end
      vas_pkg::PH_ALERT_IND,
      vas_pkg::PH_ALERT_PWM: begin
        ball_seen_nxt   = ball_or;
        spring_seen_nxt = spring_or;
        timer_nxt       = timer_inc;
        if (done) begin
          timer_nxt = '0;
          if (phase_r == vas_pkg::PH_ALERT_IND) begin
            phase_nxt = vas_pkg::PH_ALERT_PWM;
          end else if (ball_or) begin
            watch_ball_nxt = 1'b1;
            phase_nxt      = vas_pkg::PH_BALL_SLEEP;
          end else if (spring_or) begin
            // Re-entry reloads the latches from this tick alone.
            ball_seen_nxt   = ball;
            spring_seen_nxt = spring;
            phase_nxt       = vas_pkg::PH_ALERT_IND;
          end else begin
            round_nxt = '0;
            phase_nxt = vas_pkg::PH_PATROL_ON;
          end
        end
      end
      vas_pkg::PH_PATROL_ON: begin
        if (spring) begin
          ball_seen_nxt   = ball;
          spring_seen_nxt = spring;
          phase_nxt       = vas_pkg::PH_ALERT_IND;
          timer_nxt       = '0;
        end else begin
          timer_nxt = timer_inc;
          if (done) begin
            timer_nxt = '0;
            phase_nxt = vas_pkg::PH_PATROL_OFF;
          end
        end
      end
      vas_pkg::PH_PATROL_OFF: begin
        if (spring) begin
          ball_seen_nxt   = ball;
          spring_seen_nxt = spring;
          phase_nxt       = vas_pkg::PH_ALERT_IND;
          timer_nxt       = '0;
        end else begin
          timer_nxt = timer_inc;
          if (done) begin
            timer_nxt = '0;
            round_nxt = round_inc;
            if (round_inc >= cfg.patrol_rounds) begin
              watch_ball_nxt = 1'b0;
              phase_nxt      = vas_pkg::PH_SPRING_SLEEP;
            end else begin
              phase_nxt = vas_pkg::PH_PATROL_ON;
            end
          end
        end
      end
      vas_pkg::PH_BALL_SLEEP: begin
        if (ball) begin
          watch_ball_nxt = 1'b1;
          phase_nxt      = vas_pkg::PH_ARM_HOLD;
          timer_nxt      = '0;
        end
      end
      default: begin
        phase_nxt = vas_pkg::PH_ARM_WAIT;
        timer_nxt = '0;
      end
    endcase
  end

  // Result fields follow the phase after this tick.
  always_comb begin
    res_nxt.indicator_on = (phase_nxt == vas_pkg::PH_BURST_IND) ||
                           (phase_nxt == vas_pkg::PH_CHIRP_IND) ||
                           (phase_nxt == vas_pkg::PH_ALERT_IND) ||
                           (phase_nxt == vas_pkg::PH_PATROL_ON);
    res_nxt.pwm_on       = (phase_nxt == vas_pkg::PH_BURST_PWM) ||
                           (phase_nxt == vas_pkg::PH_CHIRP_PWM) ||
                           (phase_nxt == vas_pkg::PH_ALERT_PWM);
    res_nxt.asleep       = (phase_nxt == vas_pkg::PH_SPRING_SLEEP) ||
                           (phase_nxt == vas_pkg::PH_BALL_SLEEP);
    res_nxt.phase_code   = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= vas_pkg::PH_ARM_WAIT;
      timer_r       <= '0;
      round_r       <= '0;
      ball_seen_r   <= 1'b0;
      spring_seen_r <= 1'b0;
      watch_ball_r  <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      timer_r       <= timer_nxt;
      round_r       <= round_nxt;
      ball_seen_r   <= ball_seen_nxt;
      spring_seen_r <= spring_seen_nxt;
      watch_ball_r  <= watch_ball_nxt;
    end
  end

endmodule

>>> sv/vibration_alarm_sequencer.sv
// Channel   Role     Payload                                      Handshake
// in_chan   sink     ball_level, spring_level                     valid/ready
// out_chan  source   indicator_on, pwm_on, asleep, phase_code     valid/ready
// cfg_*     write    cfg_wr_en, cfg_idx[2:0], cfg_data[15:0]       no wait
//
// One request per clock unless out_chan stalls: the phase update for a tick is computed
// in the same cycle it is accepted and its result appears on out_chan on the next cycle.
// A new request is taken whenever the result register is empty or being drained,
// so a stalled result only holds off input while out_chan.ready stays low.
// Synchronous active-low reset returns the phase to arm wait and loads register defaults.
module vibration_alarm_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  vas_in_if.sink                        in_chan,
  vas_out_if.source                     out_chan,
  input  logic                          cfg_wr_en,
  input  logic [vas_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [vas_pkg::CfgDataW-1:0]  cfg_data
);

  vas_pkg::cfg_t    cfg;
  vas_pkg::result_t res_nxt;
  vas_pkg::result_t res_r;
  logic             out_valid_r;
  logic             accept;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  vas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr_en),
    .wr_idx  (cfg_idx),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  vas_phase_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .ball    (in_chan.ball_level),
    .spring  (in_chan.spring_level),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.indicator_on = res_r.indicator_on;
  assign out_chan.pwm_on       = res_r.pwm_on;
  assign out_chan.asleep       = res_r.asleep;
  assign out_chan.phase_code   = res_r.phase_code;

endmodule
